[hw/rtl/ajb_pkg.sv]
// Package for the audio jitter buffer: sizes, constants and codes.
// No dependencies.
package ajb_pkg;
  localparam int BufferDepth = 8192;
  localparam int AddrW       = $clog2(BufferDepth);
  localparam int FillW       = AddrW + 1;
  localparam int MaxBlock    = 64;
  localparam int BlkW        = $clog2(MaxBlock) + 1;
  localparam int CfgW        = 14;
  localparam int DecayQ15    = 27853;
  localparam int DecayW      = 15;
  localparam int DivW        = 16 + BlkW - 1;   // |s| * factor magnitude

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_PULL = 1'b1;

  localparam logic REG_PRIME = 1'b0;
  localparam logic REG_FADE  = 1'b1;

  typedef logic signed [15:0] sample_t;
endpackage

[hw/rtl/ajb_if.sv]
// Channel interfaces of the jitter buffer: request beats in, playback beats out.
// Depends on ajb_pkg.
interface ajb_req_if;
  import ajb_pkg::*;
  logic       valid;
  logic       ready;
  logic       mode;
  sample_t    left_in;
  sample_t    right_in;
  logic       is_mono;
  logic       first_of_packet;
  logic       last_of_packet;
  logic [8:0] packet_frames;
  logic [6:0] block_length;
  modport source(output valid, mode, left_in, right_in, is_mono, first_of_packet,
                 last_of_packet, packet_frames, block_length, input ready);
  modport sink(input valid, mode, left_in, right_in, is_mono, first_of_packet,
               last_of_packet, packet_frames, block_length, output ready);
endinterface

interface ajb_play_if;
  import ajb_pkg::*;
  logic        valid;
  logic        ready;
  sample_t     left_out;
  sample_t     right_out;
  logic        last_in_block;
  logic        is_primed;
  logic [15:0] underrun_total;
  logic [15:0] overrun_total;
  logic [15:0] peak_level;
  logic [13:0] frames_ready;
  modport source(output valid, left_out, right_out, last_in_block, is_primed,
                 underrun_total, overrun_total, peak_level, frames_ready, input ready);
  modport sink(input valid, left_out, right_out, last_in_block, is_primed,
               underrun_total, overrun_total, peak_level, frames_ready, output ready);
endinterface

[hw/rtl/audio_jitter_buffer_playout.sv]
// Top level of the stereo jitter buffer with playout sequencer.
// Depends on ajb_pkg, ajb_if (ajb_req_if, ajb_play_if) and ajb_ram.
//
//   channel  dir  payload                                   beat when
//   req      in   mode, samples, packet flags, lengths      valid & ready
//   play     out  samples, last flag, primed, counters      valid & ready
//   cfg      in   cfg_index, cfg_data                       cfg_we
//
// Push: a packet's last beat also passes S_PEAK (peak decay multiply, then max).
// Pull: S_TRIM, S_PLAN, then per frame S_FRAME and S_EMIT, with S_RD and S_RDW
// on a read, and S_MUL, S_DIV, S_FIX per channel when faded (shared multiply and
// 22-step restoring divider). The frame store is a single 8192 x 32 RAM, at most
// one read per frame. Synchronous reset clears all control state, not the store.
// req.ready is high only while idle; a pulled frame waits in the output
// register while play.ready is low, and the next frame holds until it is free.
module audio_jitter_buffer_playout (
  input  logic                      clk,
  input  logic                      rst,
  ajb_req_if.sink                   req,
  ajb_play_if.source                play,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [ajb_pkg::CfgW-1:0]  cfg_data
);
  import ajb_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PEAK  = 4'd1;
  localparam logic [3:0] S_TRIM  = 4'd2;
  localparam logic [3:0] S_PLAN  = 4'd3;
  localparam logic [3:0] S_FRAME = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_RDW   = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_FIX   = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  localparam int DcntW = $clog2(DivW);
  localparam logic [DcntW-1:0] DivLast = DcntW'(DivW - 1);

  logic [3:0] state;

  // configuration
  logic [CfgW-1:0] prime_threshold;
  logic [CfgW-1:0] fade_length;

  // buffer state
  logic [AddrW-1:0] write_index;
  logic [AddrW-1:0] read_index;
  logic [FillW-1:0] fill_count;
  logic             primed_flag;
  sample_t          lp_l, lp_r;
  logic [15:0]      underrun_counter;
  logic [15:0]      overrun_counter;
  logic [15:0]      peak_register;
  logic [15:0]      packet_peak;
  logic             packet_dropping;
  logic [30:0]      decay_prod;

  // pull sequencer
  logic [BlkW-1:0]  blk_n;
  logic [BlkW-1:0]  k;
  logic [BlkW-1:0]  avail;
  logic [BlkW-1:0]  f_in;
  logic [BlkW-1:0]  f_out;
  logic [CfgW-1:0]  fade;
  logic             pnow;
  logic             just;
  sample_t          start_l, start_r;
  sample_t          samp_l, samp_r;
  logic [BlkW-1:0]  mul_f;
  logic [BlkW-1:0]  div_d;

  // shared divider
  logic [DivW-1:0]  dnum;
  logic [BlkW-1:0]  drem;
  logic [DcntW-1:0] dcnt;
  logic             dsign;
  logic             dch;

  // RAM
  logic             ram_we;
  logic [31:0]      ram_wdata;
  logic             ram_re;
  logic [31:0]      ram_rdata;

  // ---------------- push datapath ----------------
  sample_t          push_l, push_r;
  logic [15:0]      mag_l, mag_r;
  logic [15:0]      pk_base, pk_mid, pk_new;
  logic [FillW:0]   free_space;
  logic             drop_new;
  logic             push_fire, pull_fire;

  assign push_fire = req.valid && req.ready && (req.mode == MODE_PUSH);
  assign pull_fire = req.valid && req.ready && (req.mode == MODE_PULL);

  always_comb begin
    push_l     = req.left_in;
    push_r     = req.is_mono ? req.left_in : req.right_in;
    mag_l      = push_l[15] ? 16'(-push_l) : 16'(push_l);
    mag_r      = push_r[15] ? 16'(-push_r) : 16'(push_r);
    pk_base    = req.first_of_packet ? 16'd0 : packet_peak;
    pk_mid     = (mag_l > pk_base) ? mag_l : pk_base;
    pk_new     = (mag_r > pk_mid) ? mag_r : pk_mid;
    free_space = (FillW + 1)'(BufferDepth) - {1'b0, fill_count};
    drop_new   = req.first_of_packet ? (free_space < (FillW + 1)'(req.packet_frames))
                                     : packet_dropping;
  end

  assign ram_we    = push_fire && !drop_new && (fill_count < FillW'(BufferDepth));
  assign ram_wdata = {push_l, push_r};
  assign ram_re    = (state == S_RD);

  ajb_ram #(.Width(32), .Depth(BufferDepth)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_index),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (read_index),
    .rdata (ram_rdata)
  );

  // ---------------- pull helpers ----------------
  logic [BlkW-1:0]  short_n;
  logic [BlkW-1:0]  avail_c;
  logic [BlkW-1:0]  j;
  logic [DivW:0]    prod;
  sample_t          cur_samp;
  logic [15:0]      cur_mag;
  logic [BlkW:0]    dtrial;
  sample_t          dq;
  logic             out_free;

  always_comb begin
    avail_c  = (fill_count < FillW'(blk_n)) ? BlkW'(fill_count) : blk_n;
    short_n  = blk_n - avail_c;
    j        = k - avail;
    cur_samp = dch ? samp_r : samp_l;
    cur_mag  = cur_samp[15] ? 16'(-cur_samp) : 16'(cur_samp);
    prod     = (DivW + 1)'(cur_mag * mul_f);
    dtrial   = {drem, dnum[DivW-1]};
    dq       = dsign ? sample_t'(-dnum[15:0]) : sample_t'(dnum[15:0]);
    out_free = !play.valid || play.ready;
  end

  assign req.ready = (state == S_IDLE);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      prime_threshold  <= CfgW'(1024);
      fade_length      <= CfgW'(64);
      write_index      <= '0;
      read_index       <= '0;
      fill_count       <= '0;
      primed_flag      <= 1'b0;
      lp_l             <= '0;
      lp_r             <= '0;
      underrun_counter <= '0;
      overrun_counter  <= '0;
      peak_register    <= '0;
      packet_peak      <= '0;
      packet_dropping  <= 1'b0;
      play.valid       <= 1'b0;
      k                <= '0;
      dch              <= 1'b0;
      dcnt             <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_PRIME) prime_threshold <= cfg_data;
        if (cfg_index == REG_FADE)  fade_length     <= cfg_data;
      end
      // S_EMIT reloads the output register itself when it is taken
      if (play.valid && play.ready && state != S_EMIT) begin
        play.valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (push_fire) begin
            packet_peak     <= pk_new;
            packet_dropping <= drop_new;
            if (req.first_of_packet && drop_new && overrun_counter != 16'hFFFF) begin
              overrun_counter <= overrun_counter + 16'd1;
            end
            if (ram_we) begin
              write_index <= write_index + AddrW'(1);
              fill_count  <= fill_count + FillW'(1);
            end
            if (req.last_of_packet) begin
              decay_prod <= 31'(peak_register * DecayW'(DecayQ15));
              state      <= S_PEAK;
            end
          end else if (pull_fire && req.block_length != '0) begin
            blk_n <= (req.block_length > BlkW'(MaxBlock)) ? BlkW'(MaxBlock)
                                                          : req.block_length;
            fade  <= (fade_length == '0) ? CfgW'(1) : fade_length;
            pnow  <= primed_flag || ({2'b00, fill_count} >= {1'b0, prime_threshold});
            just  <= !primed_flag && ({2'b00, fill_count} >= {1'b0, prime_threshold});
            state <= S_TRIM;
          end
        end

        S_PEAK: begin
          peak_register   <= (packet_peak > decay_prod[30:15]) ? packet_peak
                                                                : decay_prod[30:15];
          packet_dropping <= 1'b0;
          state           <= S_IDLE;
        end

        S_TRIM: begin
          // when primed, a backlog above four times the threshold drops back to the threshold
          if (pnow && {2'b00, fill_count} > {prime_threshold, 2'b00}) begin
            read_index <= read_index + AddrW'(fill_count - FillW'(prime_threshold));
            fill_count <= FillW'(prime_threshold);
          end
          state <= S_PLAN;
        end

        S_PLAN: begin
          k       <= '0;
          start_l <= lp_l;
          start_r <= lp_r;
          if (pnow) begin
            avail      <= avail_c;
            fill_count <= fill_count - FillW'(avail_c);
            f_in       <= (fade < CfgW'(avail_c)) ? BlkW'(fade) : avail_c;
            f_out      <= (fade < CfgW'(short_n)) ? BlkW'(fade) : short_n;
            if (avail_c < blk_n) begin
              primed_flag <= 1'b0;
              if (underrun_counter != 16'hFFFF) begin
                underrun_counter <= underrun_counter + 16'd1;
              end
            end else begin
              primed_flag <= 1'b1;
            end
          end else begin
            avail <= '0;
            f_in  <= '0;
            f_out <= '0;
          end
          state <= S_FRAME;
        end

        S_FRAME: begin
          dch <= 1'b0;
          if (pnow && k < avail) begin
            state <= S_RD;
          end else if (pnow && j < f_out) begin
            // fade-out tail from the last frame played
            samp_l <= start_l;
            samp_r <= start_r;
            mul_f  <= f_out - j;
            div_d  <= f_out + BlkW'(1);
            state  <= S_MUL;
          end else begin
            samp_l <= '0;
            samp_r <= '0;
            state  <= S_EMIT;
          end
        end

        S_RD: begin
          read_index <= read_index + AddrW'(1);
          state      <= S_RDW;
        end

        S_RDW: begin
          samp_l <= sample_t'(ram_rdata[31:16]);
          samp_r <= sample_t'(ram_rdata[15:0]);
          if (just && k < f_in) begin
            mul_f <= k;
            div_d <= f_in;
            state <= S_MUL;
          end else begin
            state <= S_EMIT;
          end
        end

        S_MUL: begin
          dnum  <= prod[DivW-1:0];
          drem  <= '0;
          dcnt  <= '0;
          dsign <= cur_samp[15];
          state <= S_DIV;
        end

        S_DIV: begin
          if (dtrial >= {1'b0, div_d}) begin
            drem <= BlkW'(dtrial - {1'b0, div_d});
            dnum <= {dnum[DivW-2:0], 1'b1};
          end else begin
            drem <= BlkW'(dtrial);
            dnum <= {dnum[DivW-2:0], 1'b0};
          end
          dcnt <= dcnt + DcntW'(1);
          if (dcnt == DivLast) state <= S_FIX;
        end

        S_FIX: begin
          if (dch) begin
            samp_r <= dq;
            state  <= S_EMIT;
          end else begin
            samp_l <= dq;
            dch    <= 1'b1;
            state  <= S_MUL;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            play.valid          <= 1'b1;
            play.left_out       <= samp_l;
            play.right_out      <= samp_r;
            play.last_in_block  <= (k == blk_n - BlkW'(1));
            play.is_primed      <= primed_flag;
            play.underrun_total <= underrun_counter;
            play.overrun_total  <= overrun_counter;
            play.peak_level     <= peak_register;
            play.frames_ready   <= fill_count;
            if (pnow) begin
              lp_l <= samp_l;
              lp_r <= samp_r;
            end
            if (pnow && k < avail) begin
              start_l <= samp_l;
              start_r <= samp_r;
            end
            k     <= k + BlkW'(1);
            state <= (k == blk_n - BlkW'(1)) ? S_IDLE : S_FRAME;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FillW'(BufferDepth))
    else $error("fill count above store depth");

  a_frame_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_FRAME) |-> (k < blk_n))
    else $error("frame index past block length");

  a_store_write_room: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (fill_count != FillW'(BufferDepth)))
    else $error("store write while full");
`endif
endmodule

[hw/rtl/ajb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ajb_ram #(
  parameter int Width = 32,
  parameter int Depth = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
